### hw/rtl/jcdc_pkg.sv
// shared types, constants and helpers for the julian day converter
`timescale 1ns / 1ps

package jcdc_pkg;

    // request direction
    localparam logic REQ_JD_TO_DATE = 1'b0;
    localparam logic REQ_DATE_TO_JD = 1'b1;

    // supported ranges
    localparam logic [22:0]        JD_MIN   = 23'd366;
    localparam logic [22:0]        JD_MAX   = 23'd5373557;
    localparam logic signed [14:0] YEAR_MIN = -15'sd4712;
    localparam logic signed [14:0] YEAR_MAX = 15'sd9999;

    // conversion constants
    localparam logic [23:0]        JD_OFFSET      = 24'd32082;
    localparam logic [23:0]        DAY_BIAS       = 24'd32083;
    localparam logic signed [15:0] YEAR_BIAS      = 16'sd4800;
    localparam logic [24:0]        DAYS_PER_CYCLE = 25'd1461;
    localparam logic [11:0]        CYCLE_REM_MAX  = 12'd1461;
    localparam logic [22:0]        DAYS_PER_YEAR  = 23'd365;

    // reciprocal of 1461: floor(2^25 / 1461), quotient low by at most one
    localparam int                 RECIP_1461_SHIFT = 25;
    localparam logic [39:0]        RECIP_1461       = 40'd22966;
    // reciprocal of 153: ceil(2^20 / 153), exact for numerators below 12192
    localparam int                 RECIP_153_SHIFT  = 20;
    localparam logic [23:0]        RECIP_153        = 24'd6854;

    // input transaction
    typedef struct packed {
        logic               req;
        logic [22:0]        day_number;
        logic signed [14:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
    } t_req;

    // after decode
    typedef struct packed {
        logic        req;
        logic        ok;
        logic [24:0] num;     // 4 * (jd + 32082) + 3
        logic [13:0] ybias;   // astronomical year + 4800 - a
        logic [3:0]  mshift;  // month counted from march
        logic [4:0]  day;
    } t_st1;

    // after reciprocal multiply
    typedef struct packed {
        logic        req;
        logic        ok;
        logic [24:0] num;
        logic [14:0] q0;
        logic [22:0] ydays;
        logic [11:0] yquad;
        logic [8:0]  dpart;
    } t_st2;

    // after remainder
    typedef struct packed {
        logic        req;
        logic        ok;
        logic [14:0] q0;
        logic [11:0] r0;
        logic [22:0] jd;
    } t_st3;

    // after quotient correction
    typedef struct packed {
        logic        req;
        logic        ok;
        logic [14:0] cyc;
        logic [8:0]  doy;
        logic [22:0] jd;
    } t_st4;

    // after month estimate
    typedef struct packed {
        logic        req;
        logic        ok;
        logic [14:0] cyc;
        logic [8:0]  doy;
        logic [3:0]  mshift;
        logic [22:0] jd;
    } t_st5;

    // result transaction
    typedef struct packed {
        logic [22:0]        day_number;
        logic signed [14:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic               in_range;
    } t_res;

    // days before the start of a month counted from march: (153 * m + 2) / 5
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] v;
        unique case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/jcdc_decode.sv
// first stage: range checks and operand preparation for both directions
`timescale 1ns / 1ps

module jcdc_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  jcdc_pkg::t_req  i_data,
    output logic            o_ready,
    output logic            o_valid,
    output jcdc_pkg::t_st1  o_data,
    input  logic            i_ready
);
    import jcdc_pkg::*;

    logic               r_v;
    t_st1               r_st;
    t_st1               n_st;
    logic               en;
    logic signed [14:0] ay;
    logic               leap;
    logic [4:0]         mlen;
    logic               early;
    logic signed [15:0] ysum;
    logic [23:0]        cnum;
    logic               jd_ok;
    logic               date_ok;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_data  = r_st;

    always_comb begin
        // astronomical year, 1 bc becomes 0
        ay    = (i_data.year < 15'sd0) ? i_data.year + 15'sd1 : i_data.year;
        leap  = (ay[1:0] == 2'b00);
        unique case (i_data.month)
            4'd2:                      mlen = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   mlen = 5'd30;
            default:                   mlen = 5'd31;
        endcase
        early = (i_data.month <= 4'd2);
        ysum  = 16'(ay) + YEAR_BIAS - (early ? 16'sd1 : 16'sd0);
        cnum  = 24'(i_data.day_number) + JD_OFFSET;

        jd_ok   = (i_data.day_number >= JD_MIN) && (i_data.day_number <= JD_MAX);
        date_ok = (i_data.year >= YEAR_MIN) && (i_data.year <= YEAR_MAX)
                  && (i_data.year != 15'sd0)
                  && (i_data.month >= 4'd1) && (i_data.month <= 4'd12)
                  && (i_data.day >= 5'd1) && (i_data.day <= mlen);

        n_st.req    = i_data.req;
        n_st.ok     = (i_data.req == REQ_DATE_TO_JD) ? date_ok : jd_ok;
        n_st.num    = {cnum[22:0], 2'b11};
        n_st.ybias  = ysum[13:0];
        n_st.mshift = early ? i_data.month + 4'd9 : i_data.month - 4'd3;
        n_st.day    = i_data.day;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st <= n_st;
        end
    end

endmodule

### hw/rtl/jcdc_divide.sv
// stages two to four: division by 1461 and the day number sum
`timescale 1ns / 1ps

module jcdc_divide (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  jcdc_pkg::t_st1  i_data,
    output logic            o_ready,
    output logic            o_valid,
    output jcdc_pkg::t_st4  o_data,
    input  logic            i_ready
);
    import jcdc_pkg::*;

    logic        r_v2;
    logic        r_v3;
    logic        r_v4;
    t_st2        r_st2;
    t_st3        r_st3;
    t_st4        r_st4;
    t_st2        n_st2;
    t_st3        n_st3;
    t_st4        n_st4;
    logic        en2;
    logic        en3;
    logic        en4;
    logic [39:0] prod;
    logic [24:0] qm;
    logic [23:0] jsum;
    logic [11:0] rem;

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign o_ready = en2;
    assign o_valid = r_v4;
    assign o_data  = r_st4;

    // quotient estimate by reciprocal, year days for the other direction
    always_comb begin
        prod         = 40'(i_data.num) * RECIP_1461;
        n_st2.req    = i_data.req;
        n_st2.ok     = i_data.ok;
        n_st2.num    = i_data.num;
        n_st2.q0     = 15'(prod >> RECIP_1461_SHIFT);
        n_st2.ydays  = 23'(23'(i_data.ybias) * DAYS_PER_YEAR);
        n_st2.yquad  = i_data.ybias[13:2];
        n_st2.dpart  = 9'(i_data.day) + month_offset(i_data.mshift);
    end

    // remainder of the estimate, day number total
    always_comb begin
        qm          = 25'(25'(r_st2.q0) * DAYS_PER_CYCLE);
        jsum        = 24'(r_st2.ydays) + 24'(r_st2.yquad) + 24'(r_st2.dpart) - DAY_BIAS;
        n_st3.req   = r_st2.req;
        n_st3.ok    = r_st2.ok;
        n_st3.q0    = r_st2.q0;
        n_st3.r0    = 12'(r_st2.num - qm);
        n_st3.jd    = jsum[22:0];
    end

    // estimate can be one low: fold the remainder back once
    always_comb begin
        n_st4.req = r_st3.req;
        n_st4.ok  = r_st3.ok;
        n_st4.jd  = r_st3.jd;
        if (r_st3.r0 >= CYCLE_REM_MAX) begin
            n_st4.cyc = r_st3.q0 + 15'd1;
            rem       = r_st3.r0 - CYCLE_REM_MAX;
        end else begin
            n_st4.cyc = r_st3.q0;
            rem       = r_st3.r0;
        end
        // day of the year from march is the remainder over four
        n_st4.doy = rem[10:2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= i_valid;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_st2 <= n_st2;
        end
        if (en3) begin
            r_st3 <= n_st3;
        end
        if (en4) begin
            r_st4 <= n_st4;
        end
    end

endmodule

### hw/rtl/jcdc_finish.sv
// stages five and six: month split and result formatting
`timescale 1ns / 1ps

module jcdc_finish (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  jcdc_pkg::t_st4  i_data,
    output logic            o_ready,
    output logic            o_valid,
    output jcdc_pkg::t_res  o_data,
    input  logic            i_ready
);
    import jcdc_pkg::*;

    logic               r_v5;
    logic               r_v6;
    t_st5               r_st5;
    t_res               r_res;
    t_st5               n_st5;
    t_res               n_res;
    logic               en5;
    logic               en6;
    logic [10:0]        mnum;
    logic [23:0]        mprod;
    logic               late;
    logic [8:0]         dd;
    logic signed [15:0] ys;

    assign en6     = !r_v6 || i_ready;
    assign en5     = !r_v5 || en6;
    assign o_ready = en5;
    assign o_valid = r_v6;
    assign o_data  = r_res;

    // month from march: (5 * doy + 2) / 153 by reciprocal
    always_comb begin
        mnum         = 11'(11'(i_data.doy) * 11'd5 + 11'd2);
        mprod        = 24'(mnum) * RECIP_153;
        n_st5.req    = i_data.req;
        n_st5.ok     = i_data.ok;
        n_st5.cyc    = i_data.cyc;
        n_st5.doy    = i_data.doy;
        n_st5.mshift = 4'(mprod >> RECIP_153_SHIFT);
        n_st5.jd     = i_data.jd;
    end

    always_comb begin
        late = (r_st5.mshift >= 4'd10);   // january or february of next year
        dd   = r_st5.doy - month_offset(r_st5.mshift) + 9'd1;
        ys   = signed'({1'b0, r_st5.cyc}) - YEAR_BIAS + (late ? 16'sd1 : 16'sd0);
        // no year zero: astronomical 0 is 1 bc
        if (ys < 16'sd1) begin
            ys = ys - 16'sd1;
        end
        n_res = '0;
        if (r_st5.ok) begin
            n_res.in_range = 1'b1;
            if (r_st5.req == REQ_DATE_TO_JD) begin
                n_res.day_number = r_st5.jd;
            end else begin
                n_res.year  = ys[14:0];
                n_res.month = late ? r_st5.mshift - 4'd9 : r_st5.mshift + 4'd3;
                n_res.day   = dd[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en5) begin
                r_v5 <= i_valid;
            end
            if (en6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_st5 <= n_st5;
        end
        if (en6) begin
            r_res <= n_res;
        end
    end

endmodule

### hw/rtl/julian_calendar_day_converter_unit.sv
// top level of the julian day number / julian calendar date converter
`timescale 1ns / 1ps

// julian day number <-> proleptic julian calendar date, both directions
// - slave channel: one request per transaction, tuser selects the direction
//   (0: day number to date, 1: date to day number), tdata carries the operands
// - master channel: one result per request, in request order; tuser is the
//   in-range flag, and every tdata field is zero when it is low
// - pipeline: six register stages (decode, reciprocal multiply for /1461,
//   remainder, quotient correction, month multiply for /153, result format)
// - throughput: one request per cycle while the receiver takes results; each stage holds its own valid bit
//   and fills whenever it or the stage after it is free, so bubbles close up
//   and new requests are taken while a finished result waits at the output
// - receiver stall: the output register holds its result, upstream stages
//   keep filling until the pipeline is full, then o_s_tready drops
// - reset: synchronous, active low, empties every stage; no other state

module julian_calendar_day_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // day_number_in[22:0], year_in[37:23], month_in[41:38], day_in[46:42], zero[47]
    input  logic [47:0] i_s_tdata,
    // req_type[0]
    input  logic        i_s_tuser,
    // master channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // day_number_out[22:0], year_out[37:23], month_out[41:38], day_out[46:42], zero[47]
    output logic [47:0] o_m_tdata,
    // in_range[0]
    output logic        o_m_tuser
);
    import jcdc_pkg::*;

    t_req  req;
    t_st1  st1;
    t_st4  st4;
    t_res  res;
    logic  v1;
    logic  v4;
    logic  rdy_div;
    logic  rdy_fin;

    // unpack the request transaction
    assign req.req        = i_s_tuser;
    assign req.day_number = i_s_tdata[22:0];
    assign req.year       = i_s_tdata[37:23];
    assign req.month      = i_s_tdata[41:38];
    assign req.day        = i_s_tdata[46:42];

    jcdc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_data  (req),
        .o_ready (o_s_tready),
        .o_valid (v1),
        .o_data  (st1),
        .i_ready (rdy_div)
    );

    jcdc_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .i_data  (st1),
        .o_ready (rdy_div),
        .o_valid (v4),
        .o_data  (st4),
        .i_ready (rdy_fin)
    );

    jcdc_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v4),
        .i_data  (st4),
        .o_ready (rdy_fin),
        .o_valid (o_m_tvalid),
        .o_data  (res),
        .i_ready (i_m_tready)
    );

    // pack the result transaction
    assign o_m_tdata = {1'b0, res.day, res.month, res.year, res.day_number};
    assign o_m_tuser = res.in_range;

endmodule

### hw/rtl/jcdc_checker.sv
// port level checks for the julian day converter, bound to the top level
`timescale 1ns / 1ps

module jcdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [47:0] i_s_tdata,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tuser
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result shown right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

    // an empty output stage means the whole pipeline can take a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("not ready while output empty");

    // out-of-range requests give all-zero data
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> (o_m_tdata == 48'd0))
        else $error("nonzero data on out-of-range result");

    // a good result is either a day number or a date, never both
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            ((o_m_tdata[22:0] == 23'd0) != (o_m_tdata[41:38] == 4'd0))
            && (o_m_tdata[41:38] <= 4'd12))
        else $error("malformed in-range result");

endmodule

bind julian_calendar_day_converter_unit jcdc_checker u_jcdc_checker (.*);

### tb/julian_calendar_day_converter_unit_tb.sv
// testbench for the julian day number / julian calendar date converter
`timescale 1ns / 1ps

module julian_calendar_day_converter_unit_tb;

    import jcdc_pkg::*;

    // expected conversions, in request order, and their comparison
    class calendar_scoreboard;
        t_res expected_conversions[$];
        int   mismatches;
        int   failures;

        function new();
            mismatches = 0;
            failures   = 0;
        endfunction

        function int outstanding();
            return expected_conversions.size();
        endfunction

        // days in a month; year is in calendar notation (negative for BC)
        function int days_in_month(int year, int month);
            int astro;
            astro = (year < 1) ? year + 1 : year;
            if (month == 2)
                return (astro[1:0] == 2'b00) ? 29 : 28;
            if (month == 4 || month == 6 || month == 9 || month == 11)
                return 30;
            return 31;
        endfunction

        // bit-exact model of one conversion
        function t_res convert_request(t_req r);
            t_res res;
            int   jd, c, d, e, m, dd, mm, yy;
            int   year, month, day, y, a;
            res = '0;
            if (r.req == REQ_JD_TO_DATE) begin
                jd = int'(r.day_number);
                if (jd < 366 || jd > 5373557)
                    return res;
                c  = jd + 32082;
                d  = (4 * c + 3) / 1461;
                e  = c - (1461 * d) / 4;
                m  = (5 * e + 2) / 153;
                dd = e - (153 * m + 2) / 5 + 1;
                mm = m + 3 - 12 * (m / 10);
                yy = d - 4800 + m / 10;
                // no year zero: astronomical 0 is 1 BC
                if (yy < 1)
                    yy = yy - 1;
                res.year     = yy[14:0];
                res.month    = mm[3:0];
                res.day      = dd[4:0];
                res.in_range = 1'b1;
            end else begin
                year  = int'($signed(r.year));
                month = int'(r.month);
                day   = int'(r.day);
                if (year < -4712 || year > 9999 || year == 0)
                    return res;
                if (month < 1 || month > 12)
                    return res;
                if (day < 1 || day > days_in_month(year, month))
                    return res;
                y  = (year < 1) ? year + 1 : year;
                a  = (14 - month) / 12;
                y  = y + 4800 - a;
                m  = month + 12 * a - 3;
                jd = day + (153 * m + 2) / 5 + 365 * y + y / 4 - 32083;
                res.day_number = jd[22:0];
                res.in_range   = 1'b1;
            end
            return res;
        endfunction

        function void note_request(t_req r);
            expected_conversions.push_back(convert_request(r));
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_conversions.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: jd=%0d y=%0d m=%0d d=%0d ok=%0b",
                             $time, got.day_number, got.year, got.month, got.day,
                             got.in_range);
                return;
            end
            want = expected_conversions.pop_front();
            if (got.day_number !== want.day_number || got.year !== want.year ||
                got.month !== want.month || got.day !== want.day ||
                got.in_range !== want.in_range) begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch: exp jd=%0d y=%0d m=%0d d=%0d ok=%0b, got jd=%0d y=%0d m=%0d d=%0d ok=%0b",
                             $time, want.day_number, want.year, want.month, want.day,
                             want.in_range, got.day_number, got.year, got.month, got.day,
                             got.in_range);
            end
        endfunction
    endclass

    // clock, reset and block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // day_number_in[22:0], year_in[37:23], month_in[41:38], day_in[46:42], zero[47]
    logic [47:0] i_s_tdata;
    // req_type[0]
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    // day_number_out[22:0], year_out[37:23], month_out[41:38], day_out[46:42], zero[47]
    logic [47:0] o_m_tdata;
    // in_range[0]
    logic        o_m_tuser;

    calendar_scoreboard sb;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    t_res               seen;

    julian_calendar_day_converter_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // receiver back-pressure, random per cycle at the current phase rate
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor: values read here are the ones present at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.day_number = o_m_tdata[22:0];
            seen.year       = o_m_tdata[37:23];
            seen.month      = o_m_tdata[41:38];
            seen.day        = o_m_tdata[46:42];
            seen.in_range   = o_m_tuser;
            sb.check_result(seen);
        end
    end

    // one request transaction, with random idle cycles ahead of it
    task automatic send_request(input t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, r.day, r.month, r.year, r.day_number};
        i_s_tuser  <= r.req;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        sb.note_request(r);
    endtask

    // stop sending and let every outstanding result come out
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // day number request, other fields random since they are ignored
    function automatic t_req jd_request(int jd);
        t_req r;
        r            = t_req'({$urandom, $urandom});
        r.req        = REQ_JD_TO_DATE;
        r.day_number = jd[22:0];
        return r;
    endfunction

    // date request, day number field random since it is ignored
    function automatic t_req date_request(int year, int month, int day);
        t_req r;
        r            = t_req'({$urandom, $urandom});
        r.req        = REQ_DATE_TO_JD;
        r.year       = year[14:0];
        r.month      = month[3:0];
        r.day        = day[4:0];
        return r;
    endfunction

    task automatic run_directed();
        // day number range edges
        send_request(jd_request(0));
        send_request(jd_request(365));
        send_request(jd_request(366));
        send_request(jd_request(367));
        send_request(jd_request(2299160));
        send_request(jd_request(5373557));
        send_request(jd_request(5373558));
        send_request(jd_request(8388607));
        // year range edges and the missing year zero
        send_request(date_request(-4712, 1, 1));
        send_request(date_request(9999, 12, 31));
        send_request(date_request(0, 6, 15));
        send_request(date_request(-4713, 1, 1));
        send_request(date_request(10000, 1, 1));
        send_request(date_request(1, 1, 1));
        send_request(date_request(-1, 12, 31));
        // leap day: 1 BC is leap, 2 BC is not, 1900 is leap in this calendar
        send_request(date_request(-1, 2, 29));
        send_request(date_request(-2, 2, 29));
        send_request(date_request(4, 2, 29));
        send_request(date_request(3, 2, 29));
        send_request(date_request(1900, 2, 29));
        // bad month and bad day of month
        send_request(date_request(2024, 4, 31));
        send_request(date_request(2024, 0, 1));
        send_request(date_request(2024, 13, 1));
        send_request(date_request(2024, 15, 31));
        send_request(date_request(2024, 1, 0));
    endtask

    // mostly well-formed requests with random content, some broken, some noise
    task automatic run_random(input int count);
        t_req r;
        int   pick, year, month, day, len;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                if ($urandom_range(9) == 0)
                    r = jd_request($urandom_range(1) ? 366 + $urandom_range(3)
                                                     : 5373557 - $urandom_range(3));
                else
                    r = jd_request($urandom_range(5373557, 366));
            end else if (pick < 90) begin
                year = int'($urandom_range(14711)) - 4712;
                if ($urandom_range(9) == 0)
                    year = $urandom_range(1) ? -4712 + int'($urandom_range(3))
                                             : 9999 - int'($urandom_range(3));
                if (year == 0)
                    year = -1;
                month = $urandom_range(12, 1);
                len   = sb.days_in_month(year, month);
                day   = ($urandom_range(4) == 0) ? len : $urandom_range(len, 1);
                // broken dates: one field pushed just out of range
                if (pick >= 80) begin
                    case ($urandom_range(3))
                        0: year  = 0;
                        1: month = $urandom_range(1) ? 0 : $urandom_range(15, 13);
                        2: day   = len + 1;
                        default: day = 0;
                    endcase
                end
                r = date_request(year, month, day);
            end else begin
                r = t_req'({$urandom, $urandom});
            end
            send_request(r);
        end
    endtask

    initial begin
        int idle_cfg[4];
        int stall_cfg[4];
        sb             = new();
        idle_cfg       = '{0, 67, 0, 35};
        stall_cfg      = '{0, 0, 67, 35};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = 1'b0;
        i_m_tready     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_cfg[ph];
            recv_stall_pct = stall_cfg[ph];
            if (ph == 0)
                run_directed();
            run_random(406);
            // hold off between phases until the pipeline is empty
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (sb.outstanding() != 0)
            sb.failures++;
        if (sb.failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
